// File: rtl/bfwm_pkg.sv
// Shared types, constants and helpers of the bitap fuzzy word matcher.
package bfwm_pkg;

  localparam int unsigned MASK_BITS     = 32;
  localparam int unsigned ALPHABET_SIZE = 32;
  localparam int unsigned MAX_ERRORS    = 7;

  localparam int unsigned NUM_ROWS    = MAX_ERRORS + 1;
  localparam int unsigned MASK_DEPTH  = ALPHABET_SIZE + 1;
  localparam int unsigned SYM_W       = 6;
  localparam int unsigned DIST_W      = 3;
  localparam int unsigned PLEN_W      = 5;
  localparam int unsigned WLEN_W      = 8;
  localparam int unsigned WIDX_W      = 16;
  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned DATA_W      = 32;

  localparam logic [PLEN_W-1:0] PLEN_LIMIT   = PLEN_W'(MASK_BITS - 1);
  localparam logic [SYM_W-1:0]  SYM_OUTSIDE  = SYM_W'(ALPHABET_SIZE);
  localparam logic [WLEN_W-1:0] WLEN_MAX     = '1;
  localparam logic [WIDX_W-1:0] WIDX_MAX     = '1;
  localparam logic              REG_MAX_DISTANCE = 1'b0;

  typedef logic [MASK_BITS-1:0] row_t;
  typedef row_t [NUM_ROWS-1:0]  row_arr_t;

  typedef enum logic {
    CMD_PATTERN = 1'b0,
    CMD_WORD    = 1'b1
  } cmd_e;

  localparam row_t     ROW_INIT  = row_t'(1);
  localparam row_arr_t ROWS_INIT = {NUM_ROWS{ROW_INIT}};

  function automatic logic [SYM_W-1:0] clamp_sym(input logic [SYM_W-1:0] sym);
    clamp_sym = (sym > SYM_OUTSIDE) ? SYM_OUTSIDE : sym;
  endfunction

endpackage

// File: rtl/bfwm_ram.sv
// Generic single-port-write, registered-read RAM.
module bfwm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 33
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/bfwm_rows.sv
// Unrolled chain of shift-and error row cells for one word symbol.
module bfwm_rows
  import bfwm_pkg::*;
(
  input  row_arr_t          rows_i,
  input  row_t              mask_i,
  input  logic [DIST_W-1:0] dist_i,
  output row_arr_t          rows_o
);

  always_comb begin
    row_t prev_old;
    row_t prev_new;
    row_t hit;
    row_t row;
    prev_old = '0;
    prev_new = '0;
    rows_o   = rows_i;
    for (int d = 0; d < NUM_ROWS; d++) begin
      hit = rows_i[d] & mask_i;
      row = ((prev_old | hit) << 1) | prev_old | (hit << 1) | ((prev_new | hit) << 1)
            | ROW_INIT;
      if (DIST_W'(d) <= dist_i) begin
        rows_o[d] = row;
      end
      prev_old = rows_i[d];
      prev_new = row;
    end
  end

endmodule

// File: rtl/bitap_fuzzy_word_matcher_top.sv
// Top level of the bitap fuzzy word matcher.
//
// Input channel (valid_i / stall_o): one item per accepted cycle. command_i
// selects a pattern symbol or a dictionary word symbol; last_i closes the
// pattern or the word; has_symbol_i low marks an item without a symbol.
// A pattern item after a closed pattern (or after any word item) starts a
// new pattern and restarts the word ordinal.
// Output channel (valid_o / stall_i): one item per finished word, carrying
// word_index_o and matched_o.
// Config: APB register 0 (max_distance, 3 bits); pready is tied high.
// Timing: the mask read of an item shares its accepting edge with the stage-1
// register; the row update then loads the output register when stage 1
// fires, which a held result at the output can delay.
// Throughput: one item per cycle while stall_o is low; the mask memory read
// is registered and the eight-cell row chain is combinational.
// Reset: masks, pattern, rows, counters and max_distance clear; no output
// is pending. When stall_i holds a result and a new word end waits behind
// it, stall_o rises until the output register frees up.
module bitap_fuzzy_word_matcher_top
  import bfwm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  logic              command_i,
  input  logic [SYM_W-1:0]  symbol_i,
  input  logic              has_symbol_i,
  input  logic              last_i,
  output logic              valid_o,
  input  logic              stall_i,
  output logic [WIDX_W-1:0] word_index_o,
  output logic              matched_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int unsigned MADDR_W = $clog2(MASK_DEPTH);

  logic [DIST_W-1:0] max_dist_q;

  logic              s1_valid_q, s1_valid_d;
  cmd_e              s1_cmd_q;
  logic [SYM_W-1:0]  s1_sym_q;
  logic              s1_has_q, s1_last_q;

  logic [MASK_DEPTH-1:0] mvalid_q, mvalid_d;
  logic                  fwd_valid_q;
  logic [SYM_W-1:0]      fwd_addr_q;
  row_t                  fwd_data_q;

  logic [PLEN_W-1:0] plen_q, plen_d;
  logic              open_q, open_d;
  row_arr_t          rows_q, rows_d, rows_upd, rows_after;
  logic [WLEN_W-1:0] wlen_q, wlen_d, wlen_after;
  logic [WIDX_W-1:0] wcnt_q, wcnt_d;

  logic              out_valid_q, out_valid_d;
  logic [WIDX_W-1:0] out_idx_q;
  logic              out_match_q;

  logic              accept, s1_hold, s1_fire, s1_emit;
  logic              start, mask_wr;
  logic [PLEN_W-1:0] plen_eff;
  row_t              ram_rdata, mask_raw, mask_cur, mask_old, mask_wdata;
  logic [WLEN_W-1:0] plen_ext, len_diff;
  logic              match;
  logic              cfg_wr;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[ADDR_W-1] == REG_MAX_DISTANCE) ? DATA_W'(max_dist_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q <= '0;
    end else if (cfg_wr && paddr[ADDR_W-1] == REG_MAX_DISTANCE) begin
      max_dist_q <= pwdata[DIST_W-1:0];
    end
  end

  // Handshake
  assign s1_emit = (s1_cmd_q == CMD_WORD) && s1_last_q;
  assign s1_hold = s1_valid_q && s1_emit && out_valid_q && stall_i;
  assign s1_fire = s1_valid_q && !s1_hold;
  assign stall_o = s1_hold;
  assign accept  = valid_i && !s1_hold;
  assign s1_valid_d = accept || s1_hold;

  // Symbol mask memory
  bfwm_ram #(
    .WIDTH (MASK_BITS),
    .DEPTH (MASK_DEPTH)
  ) u_mask_ram (
    .clk_i   (clk_i),
    .we_i    (mask_wr),
    .waddr_i (s1_sym_q[MADDR_W-1:0]),
    .wdata_i (mask_wdata),
    .re_i    (accept),
    .raddr_i (clamp_sym(symbol_i)),
    .rdata_o (ram_rdata)
  );

  assign mask_raw = (fwd_valid_q && fwd_addr_q == s1_sym_q) ? fwd_data_q : ram_rdata;
  assign mask_cur = mvalid_q[s1_sym_q[MADDR_W-1:0]] ? mask_raw : '0;

  assign start      = !open_q;
  assign plen_eff   = start ? '0 : plen_q;
  assign mask_old   = start ? '0 : mask_cur;
  assign mask_wdata = mask_old | (ROW_INIT << plen_eff);
  assign mask_wr    = s1_fire && (s1_cmd_q == CMD_PATTERN) && s1_has_q
                      && (plen_eff < PLEN_LIMIT);

  // Error rows
  bfwm_rows u_rows (
    .rows_i (rows_q),
    .mask_i (mask_cur),
    .dist_i (max_dist_q),
    .rows_o (rows_upd)
  );

  assign rows_after = s1_has_q ? rows_upd : rows_q;
  assign wlen_after = (s1_has_q && wlen_q != WLEN_MAX) ? wlen_q + 1'b1 : wlen_q;
  assign plen_ext   = WLEN_W'(plen_q);
  assign len_diff   = (wlen_after > plen_ext) ? wlen_after - plen_ext
                                              : plen_ext - wlen_after;
  assign match      = (len_diff <= WLEN_W'(max_dist_q))
                      && rows_after[max_dist_q][plen_q];

  always_comb begin
    mvalid_d = mvalid_q;
    plen_d   = plen_q;
    open_d   = open_q;
    rows_d   = rows_q;
    wlen_d   = wlen_q;
    wcnt_d   = wcnt_q;
    if (s1_fire) begin
      if (s1_cmd_q == CMD_PATTERN) begin
        if (start) begin
          mvalid_d = '0;
          plen_d   = '0;
          wcnt_d   = '0;
          rows_d   = ROWS_INIT;
          wlen_d   = '0;
        end
        if (mask_wr) begin
          mvalid_d[s1_sym_q[MADDR_W-1:0]] = 1'b1;
          plen_d = plen_eff + 1'b1;
        end
        open_d = !s1_last_q;
      end else begin
        open_d = 1'b0;
        rows_d = rows_after;
        wlen_d = wlen_after;
        if (s1_last_q) begin
          rows_d = ROWS_INIT;
          wlen_d = '0;
          if (wcnt_q != WIDX_MAX) begin
            wcnt_d = wcnt_q + 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire && s1_emit) begin
      out_valid_d = 1'b1;
    end else if (!stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      mvalid_q    <= '0;
      fwd_valid_q <= 1'b0;
      plen_q      <= '0;
      open_q      <= 1'b0;
      rows_q      <= ROWS_INIT;
      wlen_q      <= '0;
      wcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      mvalid_q    <= mvalid_d;
      plen_q      <= plen_d;
      open_q      <= open_d;
      rows_q      <= rows_d;
      wlen_q      <= wlen_d;
      wcnt_q      <= wcnt_d;
      out_valid_q <= out_valid_d;
      if (mask_wr) begin
        fwd_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q  <= cmd_e'(command_i);
      s1_sym_q  <= clamp_sym(symbol_i);
      s1_has_q  <= has_symbol_i;
      s1_last_q <= last_i;
    end
    if (mask_wr) begin
      fwd_addr_q <= s1_sym_q;
      fwd_data_q <= mask_wdata;
    end
    if (s1_fire && s1_emit) begin
      out_idx_q   <= wcnt_q;
      out_match_q <= match;
    end
  end

  assign valid_o      = out_valid_q;
  assign word_index_o = out_idx_q;
  assign matched_o    = out_match_q;

endmodule

// File: rtl/bfwm_checker.sv
// Port-level checker of the bitap fuzzy word matcher, bound to the top level.
module bfwm_checker
  import bfwm_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              valid_i,
  input logic              stall_o,
  input logic              valid_o,
  input logic              stall_i,
  input logic [WIDX_W-1:0] word_index_o,
  input logic              matched_o,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [DATA_W-1:0] pwdata,
  input logic [DATA_W-1:0] prdata,
  input logic              pready
);

  // Input backpressure only ever comes from a blocked output item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i))
    else $error("stall_o without a blocked output item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> (valid_o && $stable(word_index_o) && $stable(matched_o)))
    else $error("stalled output item changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && paddr[ADDR_W-1] == REG_MAX_DISTANCE)
    |=> (paddr[ADDR_W-1] != REG_MAX_DISTANCE
         || prdata[DIST_W-1:0] == $past(pwdata[DIST_W-1:0])))
    else $error("max_distance readback mismatch");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready dropped");

endmodule

bind bitap_fuzzy_word_matcher_top bfwm_checker u_bfwm_checker (.*);
